@@ design/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned ModBits  = 4;
  localparam int unsigned ModSteps = KeyW / ModBits;
  localparam int unsigned ModCntW  = $clog2(ModSteps);

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef struct packed {
    mark_e           mark;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

@@ design/lpht_ram.sv @@
`default_nettype none

module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/linear_probe_hash_table_unit.sv @@
`default_nettype none

// Open-addressing hash table with linear probing. Each item is an insert, remove or lookup of
// a 32-bit key; every item yields exactly one result with a status, the slot touched and the
// stored value for lookup hits and removals. All slots live in one synchronous RAM of SLOTS
// entries. After reset the block sweeps the RAM to mark every slot empty and accepts no item
// until the sweep ends. An item is accepted, its home-slot remainder is computed by a radix-16
// remainder unit four key bits per cycle, from 1 up to the active size of slots are then
// probed with one registered RAM read per probe, and the result is handed to the output
// register once it is free. An unused kind skips the remainder and the probe and ends with a
// missing status. The table size register may be written only while the block is idle.
module linear_probe_hash_table_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // slot[3:0], found_value[35:4], zero[39:36]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam int unsigned AddrW = $clog2(SLOTS);
  localparam int unsigned SizeW = lpht_pkg::SizeW;
  localparam int unsigned EntW  = $bits(lpht_pkg::entry_t);

  lpht_pkg::state_e  state_q, state_d;
  logic [SizeW-1:0]  cfg_q;
  logic [SizeW-1:0]  size_n;

  lpht_pkg::kind_e            kind_q, kind_d;
  logic [lpht_pkg::KeyW-1:0]  key_q, key_d;
  logic [lpht_pkg::ValW-1:0]  val_q, val_d;

  logic [lpht_pkg::KeyW-1:0]    mod_sh_q, mod_sh_d;
  logic [SizeW-1:0]             mod_rem_q, mod_rem_d, mod_rem_step;
  logic [lpht_pkg::ModCntW-1:0] mod_cnt_q, mod_cnt_d;

  logic [SizeW-1:0] pos_q, pos_d, pos_next;
  logic [SizeW-1:0] issued_q, issued_d;
  logic [SizeW-1:0] chk_pos_q, chk_pos_d;
  logic             chk_v_q, chk_v_d;
  logic [SizeW-1:0] checked_q, checked_d;
  logic             issue;

  lpht_pkg::status_e         res_status_q, res_status_d;
  logic [lpht_pkg::SlotW-1:0] res_slot_q, res_slot_d;
  logic [lpht_pkg::ValW-1:0]  res_fv_q, res_fv_d;

  logic                       m_valid_q, m_valid_d;
  lpht_pkg::status_e          m_status_q;
  logic [lpht_pkg::SlotW-1:0] m_slot_q;
  logic [lpht_pkg::ValW-1:0]  m_fv_q;
  logic                       out_load;

  logic [AddrW-1:0] clr_q, clr_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;
  lpht_pkg::entry_t rd_entry, wr_entry;

  logic s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == lpht_pkg::ST_IDLE);

  always_comb begin
    if (cfg_q == '0) begin
      size_n = SizeW'(1);
    end else if (32'(cfg_q) > SLOTS) begin
      size_n = SizeW'(SLOTS);
    end else begin
      size_n = cfg_q;
    end
  end

  always_comb begin
    logic [SizeW:0] t;
    logic [SizeW-1:0] r;
    r = mod_rem_q;
    for (int i = 0; i < int'(lpht_pkg::ModBits); i++) begin
      t = {r, mod_sh_q[lpht_pkg::KeyW-1-i]};
      if (t >= {1'b0, size_n}) begin
        t = t - {1'b0, size_n};
      end
      r = t[SizeW-1:0];
    end
    mod_rem_step = r;
  end

  assign pos_next = (SizeW'(pos_q + SizeW'(1)) == size_n) ? '0 : SizeW'(pos_q + SizeW'(1));
  assign issue    = (state_q == lpht_pkg::ST_PROBE) && (issued_q != size_n);
  assign rd_entry = lpht_pkg::entry_t'(ram_rdata);
  assign out_load = (state_q == lpht_pkg::ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    logic finish;
    logic last;
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    val_d        = val_q;
    mod_sh_d     = mod_sh_q;
    mod_rem_d    = mod_rem_q;
    mod_cnt_d    = mod_cnt_q;
    pos_d        = pos_q;
    issued_d     = issued_q;
    chk_pos_d    = chk_pos_q;
    chk_v_d      = 1'b0;
    checked_d    = checked_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_fv_d     = res_fv_q;
    clr_d        = clr_q;
    ram_we       = 1'b0;
    ram_waddr    = AddrW'(chk_pos_q);
    wr_entry     = '{mark: lpht_pkg::MARK_EMPTY, key: '0, value: '0};
    finish       = 1'b0;
    last         = (SizeW'(checked_q + SizeW'(1)) == size_n);

    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = AddrW'(clr_q + AddrW'(1));
        if (clr_q == AddrW'(SLOTS - 1)) begin
          state_d = lpht_pkg::ST_IDLE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        if (s_accept) begin
          kind_d    = lpht_pkg::kind_e'(s_axis_tuser);
          key_d     = s_axis_tdata[31:0];
          val_d     = s_axis_tdata[63:32];
          mod_sh_d  = s_axis_tdata[31:0];
          mod_rem_d = '0;
          mod_cnt_d = '0;
          if (lpht_pkg::kind_e'(s_axis_tuser) == lpht_pkg::KIND_INSERT ||
              lpht_pkg::kind_e'(s_axis_tuser) == lpht_pkg::KIND_REMOVE ||
              lpht_pkg::kind_e'(s_axis_tuser) == lpht_pkg::KIND_LOOKUP) begin
            state_d = lpht_pkg::ST_MOD;
          end else begin
            res_status_d = lpht_pkg::STATUS_MISSING;
            res_slot_d   = '0;
            res_fv_d     = '0;
            state_d      = lpht_pkg::ST_DONE;
          end
        end
      end
      lpht_pkg::ST_MOD: begin
        mod_sh_d  = mod_sh_q << lpht_pkg::ModBits;
        mod_rem_d = mod_rem_step;
        mod_cnt_d = lpht_pkg::ModCntW'(mod_cnt_q + lpht_pkg::ModCntW'(1));
        if (mod_cnt_q == lpht_pkg::ModCntW'(lpht_pkg::ModSteps - 1)) begin
          pos_d     = mod_rem_step;
          issued_d  = '0;
          checked_d = '0;
          state_d   = lpht_pkg::ST_PROBE;
        end
      end
      lpht_pkg::ST_PROBE: begin
        if (issue) begin
          pos_d     = pos_next;
          issued_d  = SizeW'(issued_q + SizeW'(1));
          chk_pos_d = pos_q;
          chk_v_d   = 1'b1;
        end
        if (chk_v_q) begin
          res_status_d = lpht_pkg::STATUS_OK;
          res_slot_d   = chk_pos_q[lpht_pkg::SlotW-1:0];
          res_fv_d     = '0;
          if (kind_q == lpht_pkg::KIND_INSERT) begin
            if (rd_entry.mark != lpht_pkg::MARK_USED) begin
              finish   = 1'b1;
              ram_we   = 1'b1;
              wr_entry = '{mark: lpht_pkg::MARK_USED, key: key_q, value: val_q};
            end else if (last) begin
              finish       = 1'b1;
              res_status_d = lpht_pkg::STATUS_FULL;
              res_slot_d   = '0;
            end
          end else begin
            if (rd_entry.mark == lpht_pkg::MARK_EMPTY) begin
              finish       = 1'b1;
              res_status_d = lpht_pkg::STATUS_MISSING;
              res_slot_d   = '0;
            end else if (rd_entry.mark == lpht_pkg::MARK_USED && rd_entry.key == key_q) begin
              finish   = 1'b1;
              res_fv_d = rd_entry.value;
              if (kind_q == lpht_pkg::KIND_REMOVE) begin
                ram_we   = 1'b1;
                wr_entry = '{mark: lpht_pkg::MARK_DELETED, key: '0, value: rd_entry.value};
              end
            end else if (last) begin
              finish       = 1'b1;
              res_status_d = lpht_pkg::STATUS_MISSING;
              res_slot_d   = '0;
            end
          end
          checked_d = SizeW'(checked_q + SizeW'(1));
          if (finish) begin
            chk_v_d = 1'b0;
            state_d = lpht_pkg::ST_DONE;
          end
        end
      end
      lpht_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = lpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpht_pkg::ST_IDLE;
      end
    endcase
  end

  assign ram_re    = issue;
  assign ram_raddr = AddrW'(pos_q);
  assign ram_wdata = EntW'(wr_entry);

  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  lpht_ram #(
    .Width(EntW),
    .Depth(SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpht_pkg::ST_CLEAR;
      cfg_q     <= SizeW'(16);
      clr_q     <= '0;
      chk_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      chk_v_q   <= chk_v_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    val_q        <= val_d;
    mod_sh_q     <= mod_sh_d;
    mod_rem_q    <= mod_rem_d;
    mod_cnt_q    <= mod_cnt_d;
    pos_q        <= pos_d;
    issued_q     <= issued_d;
    chk_pos_q    <= chk_pos_d;
    checked_q    <= checked_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_fv_q     <= res_fv_d;
    if (out_load) begin
      m_status_q <= res_status_q;
      m_slot_q   <= res_slot_q;
      m_fv_q     <= res_fv_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {4'b0, m_fv_q, m_slot_q};

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::ST_CLEAR) |-> !s_axis_tready)
    else $error("Item accepted during the clearing sweep.");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::ST_PROBE) |-> (issued_q <= size_n && checked_q < size_n))
    else $error("Probe count exceeds the active table size.");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lpht_pkg::ST_CLEAR || (state_q == lpht_pkg::ST_PROBE && chk_v_q)))
    else $error("Slot RAM written outside clearing or a probe decision.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("Block ready again right after accepting an item.");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && $past(state_q) == lpht_pkg::ST_DONE))
    else $error("Output register loaded without a finished result.");

endmodule

`default_nettype wire
